@@ design/cvk_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvk_pkg
// Shared types, codes and the kernel arithmetic of the 3x3 clamp filter.
// ----------------------------------------------------------------------------
package cvk_pkg;

  // Pixel packed as r<<16 | g<<8 | b
  typedef logic [23:0] pix_t;

  // Input operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Kernel codes; the reserved code acts as the diagonal kernel
  localparam logic [1:0] KS_EDGE    = 2'd0;
  localparam logic [1:0] KS_LAPLACE = 2'd1;
  localparam logic [1:0] KS_DIAG    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_KERNEL_SELECT = 2'd2;

  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // One job: the window after an item, and which results it yields
  typedef struct packed {
    pix_t [8:0]       win;
    logic             emit_main;
    logic             emit_tail;
    logic             frame_end;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } job_t;

  // One result beat
  typedef struct packed {
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } res_t;

  // Filter one channel and clamp to 0..255
  function automatic logic [7:0] chan_filter(input logic [8:0][7:0] t,
                                             input logic [1:0] ks);
    logic signed [12:0] x [9];
    logic signed [12:0] s;
    for (int i = 0; i < 9; i++) begin
      x[i] = $signed({5'b0, t[i]});
    end
    case (ks)
      KS_EDGE: begin
        s = (x[4] <<< 3) - (x[0] + x[1] + x[2] + x[3] + x[5] + x[6] + x[7] + x[8]);
      end
      KS_LAPLACE: begin
        s = (x[1] + x[3] + x[5] + x[7]) - (x[4] <<< 2);
      end
      default: begin
        s = (x[2] + x[6]) - (x[0] + x[8]);
      end
    endcase
    if (s < 0) begin
      return 8'd0;
    end else if (s > 13'sd255) begin
      return 8'd255;
    end else begin
      return s[7:0];
    end
  endfunction

  // Filter all three channels of a window
  function automatic pix_t filter_px(input pix_t [8:0] w, input logic [1:0] ks);
    logic [8:0][7:0] tr;
    logic [8:0][7:0] tg;
    logic [8:0][7:0] tb;
    for (int i = 0; i < 9; i++) begin
      tr[i] = w[i][23:16];
      tg[i] = w[i][15:8];
      tb[i] = w[i][7:0];
    end
    return {chan_filter(tr, ks), chan_filter(tg, ks), chan_filter(tb, ks)};
  endfunction

endpackage
`default_nettype wire

@@ design/cvk_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvk_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/cvk_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvk_front
// Accepts pixels, tracks row and column, keeps the two line stores and the
// 3x3 window, and hands one job per result-bearing item to the queue.
// ----------------------------------------------------------------------------
module cvk_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]        width_last,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]     height,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                opcode,
  input  wire logic [7:0]                          pixel_r,
  input  wire logic [7:0]                          pixel_g,
  input  wire logic [7:0]                          pixel_b,
  output logic                                     q_push,
  output cvk_pkg::job_t                            q_data,
  input  wire logic [cvk_pkg::QCW-1:0]             q_count
);
  import cvk_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // Position counters
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  // Accept-side decode
  logic          accept;
  logic [CW-1:0] c_cur;
  logic          last_cur;
  logic          flush_cur;
  pix_t          v_cur;

  // Stage after accept, line store read in flight
  logic             s1_valid;
  pix_t             s1_v;
  logic [CW-1:0]    s1_c;
  logic             s1_c0;
  logic             s1_has_top;
  logic             s1_has_mid;
  logic             s1_emit_main;
  logic             s1_emit_tail;
  logic             s1_flush;
  logic [ROW_W-1:0] s1_row;

  // Line store read data and same-address bypass
  logic [47:0] ram_q;
  logic [47:0] rd;
  logic [47:0] s1_wdata;
  logic        byp_hit;
  logic [47:0] byp_data;

  // Window
  pix_t [8:0] win;
  pix_t [8:0] win_next;
  pix_t       top;
  pix_t       mid;

  // Hold off while the queue could not take everything in flight
  always_comb begin
    full = ({1'b0, q_count} + {{QCW{1'b0}}, s1_valid}) >= (QCW+1)'(QDEPTH);
  end

  // Classify the incoming item
  always_comb begin
    accept    = push && !full;
    c_cur     = (col_count > width_last) ? width_last : col_count;
    last_cur  = (c_cur == width_last);
    flush_cur = (row_count >= height);
    v_cur     = (opcode == OP_PIXEL && !flush_cur) ? {pixel_r, pixel_g, pixel_b} : '0;
  end

  // Advance the counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_cur) begin
        col_count <= '0;
        row_count <= flush_cur ? '0 : row_count + RW'(1);
      end else begin
        col_count <= c_cur + CW'(1);
      end
    end
  end

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      byp_hit  <= accept && s1_valid && (s1_c == c_cur);
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    byp_data <= s1_wdata;
    if (accept) begin
      s1_v         <= v_cur;
      s1_c         <= c_cur;
      s1_c0        <= (c_cur == '0);
      s1_has_top   <= (row_count >= RW'(2));
      s1_has_mid   <= (row_count != '0);
      s1_emit_main <= (row_count != '0) && (c_cur != '0);
      s1_emit_tail <= (row_count != '0) && last_cur;
      s1_flush     <= flush_cur;
      s1_row       <= ROW_W'(row_count - RW'(1));
    end
  end

  // Line stores: upper in the top half, middle in the bottom half
  cvk_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_c),
    .wdata (s1_wdata),
    .raddr (c_cur),
    .rdata (ram_q)
  );

  // Shift the line stores and the window
  always_comb begin
    rd       = byp_hit ? byp_data : ram_q;
    top      = s1_has_top ? rd[47:24] : '0;
    mid      = s1_has_mid ? rd[23:0] : '0;
    s1_wdata = {rd[23:0], s1_v};
    for (int r = 0; r < 3; r++) begin
      win_next[r*3+0] = s1_c0 ? '0 : win[r*3+1];
      win_next[r*3+1] = s1_c0 ? '0 : win[r*3+2];
    end
    win_next[2] = top;
    win_next[5] = mid;
    win_next[8] = s1_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // Hand the job to the queue
  always_comb begin
    q_push           = s1_valid && (s1_emit_main || s1_emit_tail);
    q_data.win       = win_next;
    q_data.emit_main = s1_emit_main;
    q_data.emit_tail = s1_emit_tail;
    q_data.frame_end = s1_flush;
    q_data.row       = s1_row;
    q_data.col       = COL_W'(s1_c);
  end

endmodule
`default_nettype wire

@@ design/cvk_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvk_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cvk_queue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire cvk_pkg::job_t           din,
  input  wire logic                    pop,
  output cvk_pkg::job_t                head,
  output logic                         empty,
  output logic [cvk_pkg::QCW-1:0]      count
);
  import cvk_pkg::*;

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  always_comb begin
    empty = (count == '0);
    head  = mem[rd_ptr];
  end

  // Store a job
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

endmodule
`default_nettype wire

@@ design/cvk_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvk_back
// Applies the selected kernel to each queued window, one result per cycle
// unless the two-entry output queue that keeps finished results is full.
// ----------------------------------------------------------------------------
module cvk_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [1:0]                 kernel_select,
  input  wire logic                       q_empty,
  input  wire cvk_pkg::job_t              q_head,
  output logic                            q_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [7:0]                      out_r,
  output logic [7:0]                      out_g,
  output logic [7:0]                      out_b,
  output logic [cvk_pkg::ROW_W-1:0]       out_row,
  output logic [cvk_pkg::COL_W-1:0]       out_col,
  output logic                            frame_last
);
  import cvk_pkg::*;

  // Second result of a job pending
  logic phase;

  logic       fire;
  logic       do_tail;
  logic       final_res;
  pix_t [8:0] w_sel;
  pix_t       px;
  res_t       res;

  // Output queue
  res_t       omem [2];
  logic       owp;
  logic       orp;
  logic [1:0] ocnt;
  logic       ofull;
  logic       opop;
  res_t       ohead;

  // Pick the window and work out the result
  always_comb begin
    ofull     = (ocnt == 2'd2);
    fire      = !q_empty && !ofull;
    do_tail   = phase || !q_head.emit_main;
    final_res = do_tail || !q_head.emit_tail;
    q_pop     = fire && final_res;
    for (int r = 0; r < 3; r++) begin
      w_sel[r*3+0] = do_tail ? q_head.win[r*3+1] : q_head.win[r*3+0];
      w_sel[r*3+1] = do_tail ? q_head.win[r*3+2] : q_head.win[r*3+1];
      w_sel[r*3+2] = do_tail ? '0 : q_head.win[r*3+2];
    end
    px       = filter_px(w_sel, kernel_select);
    res.r    = px[23:16];
    res.g    = px[15:8];
    res.b    = px[7:0];
    res.row  = q_head.row;
    res.col  = do_tail ? q_head.col : q_head.col - COL_W'(1);
    res.last = do_tail && q_head.frame_end;
  end

  // Step through the results of a job
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (fire) begin
      phase <= !final_res;
    end
  end

  // Store a result beat
  always_ff @(posedge clk) begin
    if (fire) begin
      omem[owp] <= res;
    end
  end

  // Output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= '0;
    end else begin
      if (fire) begin
        owp <= !owp;
      end
      if (opop) begin
        orp <= !orp;
      end
      ocnt <= ocnt + 2'(fire) - 2'(opop);
    end
  end

  // Drive the result ports
  always_comb begin
    empty      = (ocnt == '0);
    opop       = pop && !empty;
    ohead      = omem[orp];
    out_r      = ohead.r;
    out_g      = ohead.g;
    out_b      = ohead.b;
    out_row    = ohead.row;
    out_col    = ohead.col;
    frame_last = ohead.last;
  end

endmodule
`default_nettype wire

@@ design/conv3x3_kernel_clamp_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_kernel_clamp_filter
// Streaming 3x3 RGB convolution with zero padding and clamping to 0..255.
//
//   channel  | handshake          | beat
//   ---------+--------------------+-------------------------------------------
//   input    | push / full        | opcode, pixel_r, pixel_g, pixel_b
//   result   | pop / empty        | out_r, out_g, out_b, out_row, out_col,
//            |                    | frame_last
//   config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pixel is accepted per cycle while full is low. In the cycle after
// acceptance the pixel reads the line stores and updates the window, and its
// job enters the job queue at the end of that cycle; the back end gives one
// result per cycle while its output queue has room, so a row-end pixel with
// two results gives them one after the other.
// Reset is synchronous and needs no clearing pass; the line stores are not
// cleared. full rises when the queued jobs plus the pixel in the line store
// stage reach four, which only happens when results back up.
// ----------------------------------------------------------------------------
module conv3x3_kernel_clamp_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            opcode,
  input  wire logic [7:0]                      pixel_r,
  input  wire logic [7:0]                      pixel_g,
  input  wire logic [7:0]                      pixel_b,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [7:0]                           out_r,
  output logic [7:0]                           out_g,
  output logic [7:0]                           out_b,
  output logic [cvk_pkg::ROW_W-1:0]            out_row,
  output logic [cvk_pkg::COL_W-1:0]            out_col,
  output logic                                 frame_last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [cvk_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cvk_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  // Registers held in clamped form
  logic [CW-1:0] width_last;
  logic [RW-1:0] height;
  logic [1:0]    kernel_select;

  logic [10:0]   iw;
  logic [12:0]   ih;
  logic [CW-1:0] width_last_next;
  logic [RW-1:0] height_next;

  // Clamp the written values into range
  always_comb begin
    cfg_ready = 1'b1;
    iw        = cfg_data[10:0];
    ih        = cfg_data[12:0];
    if (iw == '0) begin
      width_last_next = '0;
    end else if (int'(iw) > MAX_WIDTH) begin
      width_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      width_last_next = CW'(iw - 11'd1);
    end
    if (ih == '0) begin
      height_next = RW'(1);
    end else if (int'(ih) > MAX_HEIGHT) begin
      height_next = RW'(MAX_HEIGHT);
    end else begin
      height_next = RW'(ih);
    end
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_last    <= CW'(WIDTH_RST - 1);
      height        <= RW'(1);
      kernel_select <= KS_EDGE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   width_last    <= width_last_next;
        REG_IMAGE_HEIGHT:  height        <= height_next;
        REG_KERNEL_SELECT: kernel_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic           q_push;
  job_t           q_din;
  logic           q_pop;
  job_t           q_head;
  logic           q_empty;
  logic [QCW-1:0] q_count;

  cvk_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .width_last (width_last),
    .height     (height),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .pixel_r    (pixel_r),
    .pixel_g    (pixel_g),
    .pixel_b    (pixel_b),
    .q_push     (q_push),
    .q_data     (q_din),
    .q_count    (q_count)
  );

  cvk_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .count (q_count)
  );

  cvk_back u_back (
    .clk           (clk),
    .rst           (rst),
    .kernel_select (kernel_select),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_r         (out_r),
    .out_g         (out_g),
    .out_b         (out_b),
    .out_row       (out_row),
    .out_col       (out_col),
    .frame_last    (frame_last)
  );

endmodule
`default_nettype wire

@@ tb/conv3x3_kernel_clamp_filter_tb.sv @@
// ----------------------------------------------------------------------------
// conv3x3_kernel_clamp_filter_tb
// Self-checking bench for the streaming 3x3 RGB clamp filter. A scoreboard
// keeps its own line stores, window and counters, works out the filtered
// beats for every accepted pixel and compares them in order with what the
// filter pops. Frames are streamed under random and steady idling on both
// sides, with kernel, width and height changes between frames and mid-frame.
// ----------------------------------------------------------------------------
module conv3x3_kernel_clamp_filter_tb;
  import cvk_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int RANDOM_ITEMS = 400;
  localparam int WIDE_ITEMS = 30;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // Register index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Kernel code outside the list, behaves as the diagonal kernel
  localparam logic [1:0] KS_RESERVED = 2'd3;

  // One filtered pixel as it leaves the block
  typedef struct {
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } filt_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the filter state and holds the beats still owed
  // --------------------------------------------------------------------------
  class filter_scoreboard;
    pix_t             upper_line [MAX_W];
    pix_t             middle_line [MAX_W];
    logic [8:0][23:0] win;
    int unsigned      row_cnt;
    int unsigned      col_cnt;
    logic [10:0]      width_reg;
    logic [12:0]      height_reg;
    logic [1:0]       kernel_reg;
    filt_beat_t       owed_beats [$];
    int unsigned      beats_checked;
    int unsigned      errors;
    int unsigned      frames_done;

    function new();
      for (int i = 0; i < MAX_W; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      win = '0;
      row_cnt = 0;
      col_cnt = 0;
      width_reg = 11'd1024;
      height_reg = 13'd1;
      kernel_reg = KS_EDGE;
      beats_checked = 0;
      errors = 0;
      frames_done = 0;
    endfunction

    function int unsigned active_width();
      int unsigned w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      return w;
    endfunction

    function int unsigned active_height();
      int unsigned h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > MAX_H) h = MAX_H;
      return h;
    endfunction

    function bit in_flush_row();
      return row_cnt >= active_height();
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        REG_IMAGE_WIDTH:   width_reg = val[10:0];
        REG_IMAGE_HEIGHT:  height_reg = val;
        REG_KERNEL_SELECT: kernel_reg = val[1:0];
        default: ;
      endcase
    endfunction

    // Weight of window tap i; codes 2 and 3 both give the diagonal kernel
    function int tap(logic [1:0] ks, int i);
      case (ks)
        KS_EDGE:    return (i == 4) ? 8 : -1;
        KS_LAPLACE: return (i == 4) ? -4 : ((i % 2 == 1) ? 1 : 0);
        default:    return (i == 0 || i == 8) ? -1 : ((i == 2 || i == 6) ? 1 : 0);
      endcase
    endfunction

    // Convolve each channel on its own and clamp to 0..255
    function pix_t filter_window(logic [8:0][23:0] wnd);
      pix_t res;
      int   acc;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
        acc = 0;
        for (int i = 0; i < 9; i++) begin
          acc += int'(wnd[i][ch*8 +: 8]) * tap(kernel_reg, i);
        end
        if (acc < 0) acc = 0;
        else if (acc > 255) acc = 255;
        res[ch*8 +: 8] = acc[7:0];
      end
      return res;
    endfunction

    function void owe_beat(logic [8:0][23:0] wnd, int unsigned row, int unsigned col,
                           logic last);
      filt_beat_t bt;
      pix_t       p;
      p = filter_window(wnd);
      bt.r = p[23:16];
      bt.g = p[15:8];
      bt.b = p[7:0];
      bt.row = row[ROW_W-1:0];
      bt.col = col[COL_W-1:0];
      bt.last = last;
      owed_beats.push_back(bt);
    endfunction

    // Advance the mirrored state by one accepted input beat
    function void predict_pixel(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned      w;
      int unsigned      c;
      logic             flush_row;
      logic             last_col;
      pix_t             v;
      pix_t             top;
      pix_t             mid;
      logic [8:0][23:0] tail;
      w = active_width();
      c = (col_cnt > w - 1) ? w - 1 : col_cnt;
      last_col = (c == w - 1);
      flush_row = in_flush_row();
      v = '0;
      if (op == OP_PIXEL && !flush_row) v = {r, g, b};
      top = (row_cnt >= 2) ? upper_line[c] : '0;
      mid = (row_cnt >= 1) ? middle_line[c] : '0;
      upper_line[c] = middle_line[c];
      middle_line[c] = v;
      // left padding column at row start
      if (c == 0) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3+1] = '0;
          win[k*3+2] = '0;
        end
      end
      for (int k = 0; k < 3; k++) begin
        win[k*3] = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = v;
      if (row_cnt >= 1) begin
        if (c >= 1) owe_beat(win, row_cnt - 1, c - 1, 1'b0);
        // row end: one more beat with the right padding column zero
        if (last_col) begin
          for (int k = 0; k < 3; k++) begin
            tail[k*3] = win[k*3+1];
            tail[k*3+1] = win[k*3+2];
            tail[k*3+2] = '0;
          end
          owe_beat(tail, row_cnt - 1, c, flush_row);
        end
      end
      if (last_col) begin
        col_cnt = 0;
        if (flush_row) begin
          row_cnt = 0;
          frames_done++;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    // Compare a popped beat with the oldest one owed
    function void check_result(filt_beat_t got);
      filt_beat_t exp_bt;
      beats_checked++;
      if (owed_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected beat: rgb=%02x%02x%02x row=%0d col=%0d last=%0b",
                   got.r, got.g, got.b, got.row, got.col, got.last);
        end
        return;
      end
      exp_bt = owed_beats.pop_front();
      if (got.r !== exp_bt.r || got.g !== exp_bt.g || got.b !== exp_bt.b ||
          got.row !== exp_bt.row || got.col !== exp_bt.col || got.last !== exp_bt.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: exp rgb=%02x%02x%02x row=%0d col=%0d last=%0b",
                   exp_bt.r, exp_bt.g, exp_bt.b, exp_bt.row, exp_bt.col, exp_bt.last);
          $display("          got rgb=%02x%02x%02x row=%0d col=%0d last=%0b",
                   got.r, got.g, got.b, got.row, got.col, got.last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic                  opcode = OP_PIXEL;
  logic [7:0]            pixel_r = '0;
  logic [7:0]            pixel_g = '0;
  logic [7:0]            pixel_b = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            out_r;
  logic [7:0]            out_g;
  logic [7:0]            out_b;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic                  frame_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  filter_scoreboard sb = new();
  bit               steady = 1'b0;
  bit               hold_results = 1'b0;
  int unsigned      items_sent = 0;
  int unsigned      reg_writes = 0;
  int unsigned      holds_done = 0;
  int unsigned      stall_cycles = 0;

  conv3x3_kernel_clamp_filter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .pixel_r   (pixel_r),
    .pixel_g   (pixel_g),
    .pixel_b   (pixel_b),
    .empty     (empty),
    .pop       (pop),
    .out_r     (out_r),
    .out_g     (out_g),
    .out_b     (out_b),
    .out_row   (out_row),
    .out_col   (out_col),
    .frame_last(frame_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Abort when no beat of any kind moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random pop gaps, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_drain
    int         gap;
    filt_beat_t got;
    do @(negedge clk); while (rst);
    forever begin
      if (hold_results) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
        holds_done++;
      end
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.r = out_r;
      got.g = out_g;
      got.b = out_b;
      got.row = out_row;
      got.col = out_col;
      got.last = frame_last;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  // Hold the input beat until accepted, after a random gap
  task automatic send_pixel(input logic op, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    opcode <= op;
    pixel_r <= r;
    pixel_g <= g;
    pixel_b <= b;
    do @(posedge clk); while (full);
    sb.predict_pixel(op, r, g, b);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop push, wait for every owed beat, then let the pipeline run dry
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Value in the low bits, random junk above the register width
  function automatic logic [12:0] pad_junk(input int unsigned v, input int unsigned bits);
    logic [12:0] keep;
    keep = 13'((1 << bits) - 1);
    return (13'($urandom) & ~keep) | (13'(v) & keep);
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly pixels in the image, mostly flush ticks in the flush row
  task automatic send_raster_beat();
    logic op;
    if (sb.in_flush_row()) op = ($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_FLUSH;
    else op = ($urandom_range(0, 9) == 0) ? OP_FLUSH : OP_PIXEL;
    send_pixel(op, rand_chan(), rand_chan(), rand_chan());
  endtask

  task automatic send_items(input int unsigned n);
    repeat (n) send_raster_beat();
  endtask

  task automatic finish_frame();
    do send_raster_beat(); while (sb.row_cnt != 0 || sb.col_cnt != 0);
  endtask

  function automatic int unsigned pick_width();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel == 1) return 1;
    if (sel < 16) return $urandom_range(2, 8);
    return $urandom_range(9, 40);
  endfunction

  function automatic logic [12:0] pick_tall_height();
    case ($urandom_range(0, 2))
      0:       return 13'd4096;
      1:       return 13'd8191;
      default: return 13'($urandom_range(4097, 8190));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_start;
    int unsigned style;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 3x2 edge frame: clamp at both ends, flush tick in the image,
    // pixel inside the flush row
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    write_reg(REG_KERNEL_SELECT, 13'(KS_EDGE));
    send_pixel(OP_PIXEL, 8'd255, 8'd0, 8'd128);
    send_pixel(OP_PIXEL, 8'd0, 8'd255, 8'd0);
    send_pixel(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_FLUSH, 8'd77, 8'd77, 8'd77);
    send_pixel(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_FLUSH, 8'd255, 8'd255, 8'd255);
    settle();

    // Zero width acts as one column, Laplacian kernel
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_KERNEL_SELECT, 13'(KS_LAPLACE));
    send_pixel(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_PIXEL, 8'd10, 8'd200, 8'd0);
    send_pixel(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    settle();

    // Junk above the width and kernel fields, reserved kernel code
    write_reg(REG_IMAGE_WIDTH, 13'h1802);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    write_reg(REG_KERNEL_SELECT, {11'h7FF, KS_RESERVED});
    send_pixel(OP_PIXEL, 8'd0, 8'd0, 8'd255);
    send_pixel(OP_PIXEL, 8'd255, 8'd0, 8'd0);
    send_pixel(OP_FLUSH, 8'd9, 8'd9, 8'd9);
    send_pixel(OP_PIXEL, 8'd1, 8'd2, 8'd3);
    settle();

    // Diagonal kernel; a write to the unused index changes nothing
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_KERNEL_SELECT, 13'(KS_DIAG));
    write_reg(REG_UNUSED, 13'h1FFF);
    finish_frame();
    settle();

    // Hold results off for a long stretch while pixels keep coming
    steady = 1'b1;
    write_reg(REG_IMAGE_WIDTH, 13'd6);
    write_reg(REG_IMAGE_HEIGHT, 13'd6);
    hold_results = 1'b1;
    finish_frame();
    steady = 1'b0;
    settle();

    // Oversized width acts as the maximum; cut the wide row short by
    // shrinking the width, so the column count overshoots the new width
    write_reg(REG_IMAGE_WIDTH, pad_junk(2047, 11));
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    write_reg(REG_KERNEL_SELECT, pad_junk($urandom_range(0, 3), 2));
    send_items(WIDE_ITEMS);
    settle();
    write_reg(REG_IMAGE_WIDTH, pad_junk($urandom_range(1, 8), 11));
    finish_frame();
    settle();
    write_reg(REG_IMAGE_WIDTH, pad_junk(pick_width(), 11));

    // Random frames, some with settings changed mid-frame
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      settle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, pad_junk(pick_width(), 11));
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(0, 5)));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_KERNEL_SELECT, pad_junk($urandom_range(0, 3), 2));
      end
      if ($urandom_range(0, 15) == 0) write_reg(REG_UNUSED, 13'($urandom));
      style = $urandom_range(0, 9);
      if (style == 0) begin
        // very tall frame, cut short by lowering the height
        write_reg(REG_IMAGE_WIDTH, pad_junk($urandom_range(1, 3), 11));
        write_reg(REG_IMAGE_HEIGHT, pick_tall_height());
        send_items(sb.active_width() * $urandom_range(3, 6));
        settle();
        write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(0, 2)));
      end else if (style <= 3) begin
        send_items($urandom_range(1, sb.active_width() * (sb.active_height() + 1)));
        settle();
        // width may only shrink inside a frame
        case ($urandom_range(0, 2))
          0: write_reg(REG_IMAGE_WIDTH, pad_junk($urandom_range(0, sb.active_width()), 11));
          1: write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(0, 6)));
          default: write_reg(REG_KERNEL_SELECT, pad_junk($urandom_range(0, 3), 2));
        endcase
      end
      finish_frame();
    end
    steady = 1'b0;

    // Drain and give stray beats time to show up
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Streamed %0d pixel beats over %0d frames, checked %0d filtered beats.",
             items_sent, sb.frames_done, sb.beats_checked);
    $display("Made %0d register writes, %0d long result hold-off(s), %0d mismatch(es).",
             reg_writes, holds_done, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
